// ===== hdl/ksp_pkg.sv =====
// Shared types, constants and functions of the keypad servo position control unit.
package ksp_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CfgDebounce    = 4'd0;
  localparam logic [3:0] CfgCountMax    = 4'd1;
  localparam logic [3:0] CfgCompareBase = 4'd2;
  localparam logic [3:0] CfgCompareStep = 4'd3;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 16;

  // Register reset values.
  localparam logic [15:0] DebounceReset    = 16'd50;
  localparam logic [3:0]  CountMaxReset    = 4'd9;
  localparam logic [7:0]  CompareBaseReset = 8'd14;
  localparam logic [3:0]  CompareStepReset = 4'd2;

  // Keys with an action.
  localparam logic [3:0] KeyUp   = 4'h9;
  localparam logic [3:0] KeyDown = 4'h1;
  localparam logic [3:0] KeyLoad = 4'hD;

  typedef enum logic [1:0] {
    PhScan    = 2'd0,
    PhPress   = 2'd1,
    PhRelease = 2'd2,
    PhPost    = 2'd3
  } phase_e;

  // One result transaction.
  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [3:0] key_code;
    logic [3:0] position_count;
    logic [5:0] display_bits;
    logic [7:0] servo_compare;
  } res_t;

  // Key code for a row and a column of the keypad.
  function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] code;
    code = 4'h0;
    unique case ({row, col})
      4'b00_00: code = 4'hD;
      4'b00_01: code = 4'hF;
      4'b00_10: code = 4'h0;
      4'b00_11: code = 4'hE;
      4'b01_00: code = 4'hC;
      4'b01_01: code = 4'h3;
      4'b01_10: code = 4'h2;
      4'b01_11: code = 4'h1;
      4'b10_00: code = 4'hB;
      4'b10_01: code = 4'h6;
      4'b10_10: code = 4'h5;
      4'b10_11: code = 4'h4;
      4'b11_00: code = 4'hA;
      4'b11_01: code = 4'h9;
      4'b11_10: code = 4'h8;
      4'b11_11: code = 4'h7;
      default:  code = 4'h0;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/keypad_servo_position_control_unit.sv =====
// Top level of the keypad scanner with saturating servo position count.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+----------------------------
//   input   | in_valid_i, in_ready_o, row_levels_i      | one tick of row pin levels
//   output  | out_valid_o, out_ready_i, column_drive_o, | state after the tick, key
//           | key_valid_o, key_code_o, ...              | event and servo compare
//   config  | cfg_we_i, cfg_addr_i, cfg_wdata_i         | register writes, no wait
//
// Each tick transaction is applied to the scanner state in the cycle it is accepted and
// its result appears in the output register on the next cycle, or in the skid register
// while the output is stalled: one tick per cycle while input ready is high.
// A two-entry output (result register plus skid register) keeps input ready for one more
// tick after the output stalls; input ready drops only while the skid entry is full.
// Reset restores the register defaults, scanning at column 0, count 0 and compare 14.
module keypad_servo_position_control_unit #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ksp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ksp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [3:0]                   row_levels_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   column_drive_o,
  output logic                         key_valid_o,
  output logic [3:0]                   key_code_o,
  output logic [3:0]                   position_count_o,
  output logic [5:0]                   display_bits_o,
  output logic [7:0]                   servo_compare_o
);

  localparam logic [TIMER_BITS-1:0] TimerOne = TIMER_BITS'(1);

  // Configuration registers.
  logic [15:0] debounce_q;
  logic [3:0]  count_max_q;
  logic [7:0]  cmp_base_q;
  logic [3:0]  cmp_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= ksp_pkg::DebounceReset;
      count_max_q <= ksp_pkg::CountMaxReset;
      cmp_base_q  <= ksp_pkg::CompareBaseReset;
      cmp_step_q  <= ksp_pkg::CompareStepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ksp_pkg::CfgDebounce:    debounce_q  <= cfg_wdata_i;
        ksp_pkg::CfgCountMax:    count_max_q <= cfg_wdata_i[3:0];
        ksp_pkg::CfgCompareBase: cmp_base_q  <= cfg_wdata_i[7:0];
        ksp_pkg::CfgCompareStep: cmp_step_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Scanner state.
  ksp_pkg::phase_e       phase_q, phase_d;
  logic [1:0]            col_q, col_d;
  logic [1:0]            row_q, row_d;
  logic [3:0]            key_q, key_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [3:0]            count_q, count_d;
  logic [7:0]            cmp_q, cmp_d;

  logic                  fire_in, fire_out;
  logic                  key_fire;
  logic [TIMER_BITS-1:0] wait_len;
  logic [TIMER_BITS+15:0] deb_ext;
  logic                  timer_last;
  logic [7:0]            cmp_prod;
  logic [8:0]            cmp_sum;
  ksp_pkg::res_t         res_new;

  // Wait length masked to the timer width; zero acts as one.
  assign deb_ext    = {{TIMER_BITS{1'b0}}, debounce_q};
  assign wait_len   = (deb_ext[TIMER_BITS-1:0] == '0) ? TimerOne : deb_ext[TIMER_BITS-1:0];
  assign timer_last = (timer_q == '0) || (timer_q == TimerOne);
  assign cmp_prod   = {4'b0000, cmp_step_q} * {4'b0000, count_q};
  assign cmp_sum    = {1'b0, cmp_base_q} + {1'b0, cmp_prod};

  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    row_d    = row_q;
    key_d    = key_q;
    timer_d  = timer_q;
    count_d  = count_q;
    cmp_d    = cmp_q;
    key_fire = 1'b0;
    unique case (phase_q)
      ksp_pkg::PhScan: begin
        priority if (!row_levels_i[0]) begin
          row_d = 2'd0;
        end else if (!row_levels_i[1]) begin
          row_d = 2'd1;
        end else if (!row_levels_i[2]) begin
          row_d = 2'd2;
        end else if (!row_levels_i[3]) begin
          row_d = 2'd3;
        end else begin
          row_d = row_q;
        end
        if (row_levels_i != 4'hF) begin
          key_d   = ksp_pkg::key_lookup(row_d, col_q);
          timer_d = wait_len;
          phase_d = ksp_pkg::PhPress;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      ksp_pkg::PhPress: begin
        if (timer_last) begin
          timer_d = '0;
          phase_d = ksp_pkg::PhRelease;
        end else begin
          timer_d = timer_q - TimerOne;
        end
      end
      ksp_pkg::PhRelease: begin
        if (row_levels_i[row_q]) begin
          timer_d = wait_len;
          phase_d = ksp_pkg::PhPost;
        end
      end
      ksp_pkg::PhPost: begin
        if (timer_last) begin
          timer_d  = '0;
          key_fire = 1'b1;
          col_d    = 2'd0;
          phase_d  = ksp_pkg::PhScan;
          if (key_q == ksp_pkg::KeyUp && count_q < count_max_q) begin
            count_d = count_q + 4'd1;
          end
          if (key_q == ksp_pkg::KeyDown && count_q != 4'd0) begin
            count_d = count_q - 4'd1;
          end
          if (key_q == ksp_pkg::KeyLoad) begin
            cmp_d = cmp_sum[8] ? 8'hFF : cmp_sum[7:0];
          end
        end else begin
          timer_d = timer_q - TimerOne;
        end
      end
      default: ;
    endcase

    res_new.column_drive   = ~(4'b0001 << col_d);
    res_new.key_valid      = key_fire;
    res_new.key_code       = key_fire ? key_q : 4'h0;
    res_new.position_count = count_d;
    res_new.display_bits   = {count_d[0], count_d[1], count_d[2], count_d[3], 2'b00};
    res_new.servo_compare  = cmp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ksp_pkg::PhScan;
      col_q   <= 2'd0;
      row_q   <= 2'd0;
      key_q   <= 4'h0;
      timer_q <= '0;
      count_q <= 4'd0;
      cmp_q   <= ksp_pkg::CompareBaseReset;
    end else if (fire_in) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      key_q   <= key_d;
      timer_q <= timer_d;
      count_q <= count_d;
      cmp_q   <= cmp_d;
    end
  end

  // Output register with a skid entry behind it.
  logic          out_vld_q, skid_vld_q;
  ksp_pkg::res_t out_q, skid_q;

  assign in_ready_o = !skid_vld_q;
  assign fire_in    = in_valid_i && in_ready_o;
  assign fire_out   = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (fire_out) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else if (!fire_in) begin
          out_vld_q <= 1'b0;
        end
      end else if (fire_in) begin
        if (out_vld_q) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out && skid_vld_q) begin
      out_q <= skid_q;
    end else if (fire_in && (fire_out || !out_vld_q)) begin
      out_q <= res_new;
    end
    if (fire_in && out_vld_q && !fire_out) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign column_drive_o   = out_q.column_drive;
  assign key_valid_o      = out_q.key_valid;
  assign key_code_o       = out_q.key_code;
  assign position_count_o = out_q.position_count;
  assign display_bits_o   = out_q.display_bits;
  assign servo_compare_o  = out_q.servo_compare;

endmodule

// ===== hdl/ksp_checker.sv =====
// Port-level assertions for the keypad servo position control unit, with its bind.
module ksp_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] column_drive_o,
  input logic       key_valid_o,
  input logic [3:0] key_code_o,
  input logic [3:0] position_count_o,
  input logic [5:0] display_bits_o,
  input logic [7:0] servo_compare_o
);

  // A stalled result transaction stays valid and keeps its count, compare, key flag and column strobe.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_count_o)
      && $stable(servo_compare_o) && $stable(key_valid_o) && $stable(column_drive_o))
    else $error("stalled result changed");

  // Exactly one column is strobed low in every result.
  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(column_drive_o) == 3)
    else $error("column strobe is not one-cold");

  // The key code is zero unless a key is reported.
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !key_valid_o |-> key_code_o == 4'h0)
    else $error("key code without key event");

  // The display lines show the count bit-reversed.
  a_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> display_bits_o == {position_count_o[0], position_count_o[1],
                                       position_count_o[2], position_count_o[3], 2'b00})
    else $error("display does not match count");

  // Scanning restarts at column zero after a key event.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_valid_o |-> column_drive_o == 4'b1110)
    else $error("scan did not restart at column zero");

endmodule

bind keypad_servo_position_control_unit ksp_port_checks u_ksp_port_checks (.*);
